// ===== rtl/core/mspp_pkg.sv =====
// shared types, constants and helpers of the multi-page shelf packer
package mspp_pkg;

   localparam int PAGE_SLOTS = 16;
   localparam int ADDR_W     = (PAGE_SLOTS > 1) ? $clog2(PAGE_SLOTS) : 1;
   localparam int OPEN_W     = $clog2(PAGE_SLOTS + 1);

   localparam int DIM_W      = 13;
   localparam int MAXP_W     = 5;
   localparam int POS_W      = 12;
   localparam int PAGE_W     = 4;
   localparam int SUM_W      = 15;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [DIM_W-1:0]  PAGE_SIZE_RESET = 13'd1024;
   localparam logic [MAXP_W-1:0] MAX_PAGES_RESET = 5'd16;

   localparam logic REG_PAGE_SIZE = 1'b0;
   localparam logic REG_MAX_PAGES = 1'b1;

   typedef enum logic [1:0] {
      ST_PLACED    = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_BUDGET    = 2'd2,
      ST_TOO_LARGE = 2'd3
   } status_type;

   typedef struct packed {
      logic [DIM_W-1:0] rect_width;
      logic [DIM_W-1:0] rect_height;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [PAGE_W-1:0] page_index;
      logic [POS_W-1:0]  x_pos;
      logic [POS_W-1:0]  y_pos;
   } rsp_type;

   typedef struct packed {
      logic [DIM_W-1:0]  page_size;
      logic [MAXP_W-1:0] max_pages;
   } cfg_type;

   typedef struct packed {
      logic [DIM_W-1:0] cursor_x;
      logic [DIM_W-1:0] cursor_y;
      logic [DIM_W-1:0] shelf_height;
   } page_entry_type;

   typedef struct packed {
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      page_entry_type    wr_data;
   } mem_req_type;

   function automatic logic [PAGE_W-1:0] to_page_index(input logic [ADDR_W-1:0] idx);
      logic [31:0] wide;
      wide = 32'(idx);
      return wide[PAGE_W-1:0];
   endfunction

endpackage

// ===== rtl/core/mspp_csr.sv =====
// configuration registers of the shelf packer on an apb-style port
module mspp_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [mspp_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [mspp_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [mspp_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                               pready,
   output mspp_pkg::cfg_type                  cfg
);
   import mspp_pkg::*;

   logic [DIM_W-1:0]  page_size_ff;
   logic [MAXP_W-1:0] max_pages_ff;
   logic              wr_strobe;

   assign wr_strobe = psel && penable && pwrite;
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         page_size_ff <= PAGE_SIZE_RESET;
         max_pages_ff <= MAX_PAGES_RESET;
      end else if (wr_strobe) begin
         unique case (paddr[2])
            REG_PAGE_SIZE: page_size_ff <= pwdata[DIM_W-1:0];
            REG_MAX_PAGES: max_pages_ff <= pwdata[MAXP_W-1:0];
            default:       page_size_ff <= page_size_ff;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_PAGE_SIZE: prdata = CSR_DATA_W'(page_size_ff);
         REG_MAX_PAGES: prdata = CSR_DATA_W'(max_pages_ff);
         default:       prdata = '0;
      endcase
   end

   assign cfg.page_size = page_size_ff;
   assign cfg.max_pages = max_pages_ff;

endmodule

// ===== rtl/core/mspp_page_ram.sv =====
// page state memory: cursor and shelf height of each page, registered read
module mspp_page_ram (
   input  logic                     clock,
   input  mspp_pkg::mem_req_type    mem_req,
   output mspp_pkg::page_entry_type rd_data
);
   import mspp_pkg::*;

   page_entry_type page_mem [PAGE_SLOTS];
   page_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         page_mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= page_mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/mspp_walker.sv =====
// first-fit page walk, new page opening and result register
module mspp_walker (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  mspp_pkg::req_type        req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output mspp_pkg::rsp_type        rsp_data,
   input  mspp_pkg::cfg_type        cfg,
   output mspp_pkg::mem_req_type    mem_req,
   input  mspp_pkg::page_entry_type mem_rd_data
);
   import mspp_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_SCAN,
      S_NEW,
      S_EMIT
   } state_type;

   state_type         state_ff;
   logic [DIM_W-1:0]  w_ff;
   logic [DIM_W-1:0]  h_ff;
   logic [ADDR_W-1:0] scan_idx_ff;
   logic [OPEN_W-1:0] pages_open_ff;
   rsp_type           res_ff;
   logic              wr_pend_ff;
   logic [ADDR_W-1:0] wr_addr_ff;
   page_entry_type    wr_data_ff;
   logic              open_pend_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;

   logic              slot_free;
   logic              is_empty;
   logic              too_large;
   logic [31:0]       budget;
   logic              exhausted;
   logic              last_page;
   logic [SUM_W-1:0]  page_sz;
   logic [SUM_W-1:0]  x_end;
   logic              wrap;
   logic [SUM_W-1:0]  x_new;
   logic [SUM_W-1:0]  y_new;
   logic [DIM_W-1:0]  shelf_new;
   logic              fit;
   logic [SUM_W-1:0]  x_next;
   page_entry_type    scan_wb;
   page_entry_type    open_wb;
   logic [ADDR_W-1:0] open_addr;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign is_empty  = (w_ff == '0) || (h_ff == '0);
   assign too_large = ((SUM_W'(w_ff) + SUM_W'(2)) > SUM_W'(cfg.page_size))
                   || ((SUM_W'(h_ff) + SUM_W'(2)) > SUM_W'(cfg.page_size));
   assign budget    = (32'(cfg.max_pages) < PAGE_SLOTS) ? 32'(cfg.max_pages) : PAGE_SLOTS;
   assign exhausted = 32'(pages_open_ff) >= budget;
   assign last_page = (32'(scan_idx_ff) + 32'd1) == 32'(pages_open_ff);
   assign page_sz   = SUM_W'(cfg.page_size);

   // shelf wrap is tried on the page being read, written back only if taken
   assign x_end     = SUM_W'(mem_rd_data.cursor_x) + SUM_W'(w_ff) + SUM_W'(1);
   assign wrap      = x_end > page_sz;
   assign x_new     = wrap ? SUM_W'(1) : SUM_W'(mem_rd_data.cursor_x);
   assign y_new     = wrap ? (SUM_W'(mem_rd_data.cursor_y) + SUM_W'(mem_rd_data.shelf_height)
                              + SUM_W'(1))
                           : SUM_W'(mem_rd_data.cursor_y);
   assign shelf_new = wrap ? '0 : mem_rd_data.shelf_height;
   assign fit       = (y_new + SUM_W'(h_ff) + SUM_W'(1)) <= page_sz;
   assign x_next    = x_new + SUM_W'(w_ff) + SUM_W'(1);

   assign scan_wb.cursor_x     = x_next[DIM_W-1:0];
   assign scan_wb.cursor_y     = y_new[DIM_W-1:0];
   assign scan_wb.shelf_height = (shelf_new > h_ff) ? shelf_new : h_ff;

   assign open_wb.cursor_x     = w_ff + DIM_W'(2);
   assign open_wb.cursor_y     = DIM_W'(1);
   assign open_wb.shelf_height = h_ff;
   assign open_addr            = pages_open_ff[ADDR_W-1:0];

   always_comb begin
      mem_req.rd_en   = 1'b0;
      mem_req.rd_addr = scan_idx_ff + ADDR_W'(1);
      if (state_ff == S_CHECK) begin
         mem_req.rd_en   = !is_empty && !too_large && (pages_open_ff != '0);
         mem_req.rd_addr = '0;
      end else if (state_ff == S_SCAN) begin
         mem_req.rd_en   = !fit && !last_page;
      end
      mem_req.wr_en   = (state_ff == S_EMIT) && slot_free && wr_pend_ff;
      mem_req.wr_addr = wr_addr_ff;
      mem_req.wr_data = wr_data_ff;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         pages_open_ff <= '0;
         wr_pend_ff    <= 1'b0;
         open_pend_ff  <= 1'b0;
      end else begin
         if ((state_ff == S_EMIT) && slot_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  w_ff     <= req_data.rect_width;
                  h_ff     <= req_data.rect_height;
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               wr_pend_ff   <= 1'b0;
               open_pend_ff <= 1'b0;
               scan_idx_ff  <= '0;
               priority if (is_empty) begin
                  res_ff   <= '{status: ST_EMPTY, page_index: '0, x_pos: '0, y_pos: '0};
                  state_ff <= S_EMIT;
               end else if (too_large) begin
                  res_ff   <= '{status: ST_TOO_LARGE, page_index: '0, x_pos: '0, y_pos: '0};
                  state_ff <= S_EMIT;
               end else if (pages_open_ff == '0) begin
                  state_ff <= S_NEW;
               end else begin
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               priority if (fit) begin
                  res_ff     <= '{status: ST_PLACED,
                                  page_index: to_page_index(scan_idx_ff),
                                  x_pos: x_new[POS_W-1:0],
                                  y_pos: y_new[POS_W-1:0]};
                  wr_pend_ff <= 1'b1;
                  wr_addr_ff <= scan_idx_ff;
                  wr_data_ff <= scan_wb;
                  state_ff   <= S_EMIT;
               end else if (last_page) begin
                  state_ff <= S_NEW;
               end else begin
                  scan_idx_ff <= scan_idx_ff + ADDR_W'(1);
               end
            end
            S_NEW: begin
               if (exhausted) begin
                  res_ff <= '{status: ST_BUDGET, page_index: '0, x_pos: '0, y_pos: '0};
               end else begin
                  res_ff       <= '{status: ST_PLACED,
                                    page_index: to_page_index(open_addr),
                                    x_pos: POS_W'(1),
                                    y_pos: POS_W'(1)};
                  wr_pend_ff   <= 1'b1;
                  open_pend_ff <= 1'b1;
                  wr_addr_ff   <= open_addr;
                  wr_data_ff   <= open_wb;
               end
               state_ff <= S_EMIT;
            end
            S_EMIT: begin
               if (slot_free) begin
                  rsp_data_ff  <= res_ff;
                  wr_pend_ff   <= 1'b0;
                  open_pend_ff <= 1'b0;
                  if (open_pend_ff) begin
                     pages_open_ff <= pages_open_ff + OPEN_W'(1);
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ===== rtl/core/multi_page_shelf_packer_top.sv =====
// path to rsp_valid: S_CHECK then S_EMIT for an empty or too-large size, else S_CHECK, S_SCAN over
// the open pages up to the fitting one, then S_EMIT, or S_NEW and S_EMIT if none fits or none is open
// throughput: one transaction at a time, the walk reads one open page per cycle from the page memory
// a finished result waits in the output register while the next transaction is taken
// reset is synchronous: no pages open, registers at their defaults, page memory not cleared
module multi_page_shelf_packer_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  mspp_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output mspp_pkg::rsp_type               rsp_data,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [mspp_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [mspp_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [mspp_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);
   import mspp_pkg::*;

   cfg_type        cfg;
   mem_req_type    mem_req;
   page_entry_type mem_rd_data;

   mspp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   mspp_page_ram u_page_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (mem_rd_data)
   );

   mspp_walker u_walker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .cfg         (cfg),
      .mem_req     (mem_req),
      .mem_rd_data (mem_rd_data)
   );

   // unplaced results carry no position
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status != ST_PLACED)) |->
         ((rsp_data.page_index == '0) && (rsp_data.x_pos == '0) && (rsp_data.y_pos == '0)))
      else $error("unplaced result with nonzero position");

   // the walker is busy in the cycle after taking a transaction
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input taken again while walk in progress");

   // no result straight out of reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // memory is never read and written at the same time
   assert property (@(posedge clock) disable iff (reset)
      !(mem_req.rd_en && mem_req.wr_en))
      else $error("page memory read and write overlap");

endmodule
